// File: design/mpt_pkg.sv
package mpt_pkg;

  // Default raw pointer field and display size
  localparam int DEF_RAW_WIDTH      = 640;
  localparam int DEF_RAW_HEIGHT     = 400;
  localparam int DEF_DISPLAY_WIDTH  = 640;
  localparam int DEF_DISPLAY_HEIGHT = 400;

  // Field widths
  localparam int MASK_W   = 7;
  localparam int BTN_W    = 3;
  localparam int MICKEY_W = 16;
  localparam int COORD_W  = 12;
  localparam int FLAGS_W  = 9;
  localparam int MARKS_W  = 6;

  // APB port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_HAS_FOCUS       = 2'd0,
    REG_DISPLAY_PRESENT = 2'd1,
    REG_DISPLAY_WIDTH   = 2'd2,
    REG_DISPLAY_HEIGHT  = 2'd3
  } reg_idx_t;

  // Event mask bits
  localparam int EV_MOVE      = 0;
  localparam int EV_L_PRESS   = 1;
  localparam int EV_L_RELEASE = 2;

  // Pending mark bits (event mask bit k+1 lands in mark bit k)
  localparam int MK_L_DOWN = 0;
  localparam int MK_L_UP   = 1;
  localparam int MK_R_DOWN = 2;
  localparam int MK_R_UP   = 3;
  localparam int MK_M_DOWN = 4;
  localparam int MK_M_UP   = 5;

  typedef struct packed {
    logic has_focus;
    logic display_present;
  } cfg_flags_t;

endpackage

// File: design/mpt_in_if.sv
interface mpt_in_if import mpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [MASK_W-1:0]   event_mask;
  logic [BTN_W-1:0]    button_bits;
  logic [MICKEY_W-1:0] mickey_x;
  logic [MICKEY_W-1:0] mickey_y;

  modport source (
    output valid, opcode, event_mask, button_bits, mickey_x, mickey_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, event_mask, button_bits, mickey_x, mickey_y,
    output ready
  );
endinterface

// File: design/mpt_out_if.sv
interface mpt_out_if import mpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLAGS_W-1:0] click_flags;
  logic [COORD_W-1:0] pointer_x;
  logic [COORD_W-1:0] pointer_y;
  logic [COORD_W-1:0] press_x;
  logic [COORD_W-1:0] press_y;
  logic [COORD_W-1:0] release_x;
  logic [COORD_W-1:0] release_y;

  modport source (
    output valid, click_flags, pointer_x, pointer_y, press_x, press_y,
           release_x, release_y,
    input  ready
  );

  modport sink (
    input  valid, click_flags, pointer_x, pointer_y, press_x, press_y,
           release_x, release_y,
    output ready
  );
endinterface

// File: design/mpt_cfg.sv
module mpt_cfg import mpt_pkg::*; #(
  parameter int RAW_WIDTH  = DEF_RAW_WIDTH,
  parameter int RAW_HEIGHT = DEF_RAW_HEIGHT,
  localparam int RWX  = $clog2(RAW_WIDTH),
  localparam int RWY  = $clog2(RAW_HEIGHT),
  localparam int S_X  = 2*RWX + 12,
  localparam int S_Y  = 2*RWY + 12,
  localparam int KWX  = S_X - RWX + 2 + COORD_W,
  localparam int KWY  = S_Y - RWY + 2 + COORD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_flags_t        flags,
  output logic [KWX-1:0]    kx,
  output logic [KWY-1:0]    ky
);

  // ceil(2^S / RAW) reciprocals; kx/ky fold the display size in
  localparam logic [63:0] M_X =
    ((64'd1 << S_X) + 64'(RAW_WIDTH) - 64'd1) / 64'(RAW_WIDTH);
  localparam logic [63:0] M_Y =
    ((64'd1 << S_Y) + 64'(RAW_HEIGHT) - 64'd1) / 64'(RAW_HEIGHT);
  localparam logic [63:0] KX_RST = 64'(DEF_DISPLAY_WIDTH) * M_X;
  localparam logic [63:0] KY_RST = 64'(DEF_DISPLAY_HEIGHT) * M_Y;

  logic               has_focus;
  logic               display_present;
  logic [COORD_W-1:0] display_width;
  logic [COORD_W-1:0] display_height;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      has_focus       <= 1'b0;
      display_present <= 1'b0;
      display_width   <= COORD_W'(DEF_DISPLAY_WIDTH);
      display_height  <= COORD_W'(DEF_DISPLAY_HEIGHT);
      kx              <= KX_RST[KWX-1:0];
      ky              <= KY_RST[KWY-1:0];
    end else if (wr_en) begin
      case (idx)
        REG_HAS_FOCUS:       has_focus <= pwdata[0];
        REG_DISPLAY_PRESENT: display_present <= pwdata[0];
        REG_DISPLAY_WIDTH: begin
          display_width <= pwdata[COORD_W-1:0];
          kx <= KWX'(64'(pwdata[COORD_W-1:0]) * M_X);
        end
        REG_DISPLAY_HEIGHT: begin
          display_height <= pwdata[COORD_W-1:0];
          ky <= KWY'(64'(pwdata[COORD_W-1:0]) * M_Y);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HAS_FOCUS:       prdata = APB_DW'(has_focus);
      REG_DISPLAY_PRESENT: prdata = APB_DW'(display_present);
      REG_DISPLAY_WIDTH:   prdata = APB_DW'(display_width);
      REG_DISPLAY_HEIGHT:  prdata = APB_DW'(display_height);
      default:             prdata = '0;
    endcase
  end

  assign flags.has_focus       = has_focus;
  assign flags.display_present = display_present;

endmodule

// File: design/mpt_core.sv
module mpt_core import mpt_pkg::*; #(
  parameter int RAW_WIDTH  = DEF_RAW_WIDTH,
  parameter int RAW_HEIGHT = DEF_RAW_HEIGHT,
  localparam int RWX  = $clog2(RAW_WIDTH),
  localparam int RWY  = $clog2(RAW_HEIGHT),
  localparam int S_X  = 2*RWX + 12,
  localparam int S_Y  = 2*RWY + 12,
  localparam int KWX  = S_X - RWX + 2 + COORD_W,
  localparam int KWY  = S_Y - RWY + 2 + COORD_W
) (
  input  logic           clk,
  input  logic           rst,
  input  cfg_flags_t     flags,
  input  logic [KWX-1:0] kx,
  input  logic [KWY-1:0] ky,
  mpt_in_if.sink         in_ch,
  mpt_out_if.source      out_ch
);

  localparam int SUM_W = MICKEY_W + 2;
  localparam logic signed [SUM_W-1:0] TOP_X = SUM_W'(RAW_WIDTH - 1);
  localparam logic signed [SUM_W-1:0] TOP_Y = SUM_W'(RAW_HEIGHT - 1);

  // input stage
  logic                s1_valid;
  opcode_t             s1_op;
  logic [MASK_W-1:0]   s1_mask;
  logic [BTN_W-1:0]    s1_buttons;
  logic [MICKEY_W-1:0] s1_mx;
  logic [MICKEY_W-1:0] s1_my;
  logic                advance;

  // tracker state
  logic [MICKEY_W-1:0] last_mx;
  logic [MICKEY_W-1:0] last_my;
  logic [RWX-1:0]      raw_x;
  logic [RWY-1:0]      raw_y;
  logic [COORD_W-1:0]  screen_x;
  logic [COORD_W-1:0]  screen_y;
  logic [BTN_W-1:0]    held_buttons;
  logic [MARKS_W-1:0]  pending;
  logic [COORD_W-1:0]  lp_x, lp_y, lr_x, lr_y;

  // update logic
  logic signed [MICKEY_W-1:0] dx, dy;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic [RWX-1:0]             raw_x_next;
  logic [RWY-1:0]             raw_y_next;
  logic [RWX+KWX-1:0]         prod_x;
  logic [RWY+KWY-1:0]         prod_y;
  logic [COORD_W-1:0]         screen_x_next, screen_y_next;
  logic                       take_ev, take_move, is_query;
  logic [FLAGS_W-1:0]         flags_q;

  assign advance     = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op      <= opcode_t'(in_ch.opcode);
      s1_mask    <= in_ch.event_mask;
      s1_buttons <= in_ch.button_bits;
      s1_mx      <= in_ch.mickey_x;
      s1_my      <= in_ch.mickey_y;
    end
  end

  assign is_query  = (s1_op == OP_QUERY);
  assign take_ev   = !is_query && flags.has_focus;
  assign take_move = take_ev && s1_mask[EV_MOVE];

  // 16-bit wrapped deltas, then clamp into the raw field
  always_comb begin
    dx    = $signed(s1_mx - last_mx);
    dy    = $signed(s1_my - last_my);
    sum_x = $signed(SUM_W'(raw_x)) + SUM_W'(dx);
    sum_y = $signed(SUM_W'(raw_y)) + SUM_W'(dy);
    if (sum_x < 0)          raw_x_next = '0;
    else if (sum_x > TOP_X) raw_x_next = RWX'(RAW_WIDTH - 1);
    else                    raw_x_next = sum_x[RWX-1:0];
    if (sum_y < 0)          raw_y_next = '0;
    else if (sum_y > TOP_Y) raw_y_next = RWY'(RAW_HEIGHT - 1);
    else                    raw_y_next = sum_y[RWY-1:0];
  end

  // raw*size/RAW as one multiply by a precomputed reciprocal factor
  assign prod_x = (RWX+KWX)'(raw_x_next) * (RWX+KWX)'(kx);
  assign prod_y = (RWY+KWY)'(raw_y_next) * (RWY+KWY)'(ky);

  always_comb begin
    screen_x_next = screen_x;
    screen_y_next = screen_y;
    if (take_move) begin
      screen_x_next = flags.display_present ? prod_x[S_X+COORD_W-1:S_X] : '0;
      screen_y_next = flags.display_present ? prod_y[S_Y+COORD_W-1:S_Y] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mx      <= '0;
      last_my      <= '0;
      raw_x        <= '0;
      raw_y        <= '0;
      screen_x     <= '0;
      screen_y     <= '0;
      held_buttons <= '0;
      pending      <= '0;
      lp_x         <= '0;
      lp_y         <= '0;
      lr_x         <= '0;
      lr_y         <= '0;
    end else if (advance) begin
      if (is_query) begin
        pending <= '0;
      end else if (take_ev) begin
        held_buttons <= s1_buttons;
        pending      <= pending | s1_mask[MASK_W-1:1];
        screen_x     <= screen_x_next;
        screen_y     <= screen_y_next;
        if (take_move) begin
          last_mx <= s1_mx;
          last_my <= s1_my;
          raw_x   <= raw_x_next;
          raw_y   <= raw_y_next;
        end
        if (s1_mask[EV_L_PRESS]) begin
          lp_x <= screen_x_next;
          lp_y <= screen_y_next;
        end
        if (s1_mask[EV_L_RELEASE]) begin
          lr_x <= screen_x_next;
          lr_y <= screen_y_next;
        end
      end
    end
  end

  assign flags_q = {pending[MK_M_UP], pending[MK_R_UP], pending[MK_L_UP],
                    pending[MK_M_DOWN], pending[MK_R_DOWN], pending[MK_L_DOWN],
                    held_buttons};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.pointer_x <= screen_x_next;
      out_ch.pointer_y <= screen_y_next;
      if (is_query) begin
        out_ch.click_flags <= flags_q;
        out_ch.press_x     <= pending[MK_L_DOWN] ? lp_x : '0;
        out_ch.press_y     <= pending[MK_L_DOWN] ? lp_y : '0;
        out_ch.release_x   <= pending[MK_L_UP] ? lr_x : '0;
        out_ch.release_y   <= pending[MK_L_UP] ? lr_y : '0;
      end else begin
        out_ch.click_flags <= '0;
        out_ch.press_x     <= '0;
        out_ch.press_y     <= '0;
        out_ch.release_x   <= '0;
        out_ch.release_y   <= '0;
      end
    end
  end

`ifndef SYNTH
  a_query_clears: assert property (@(posedge clk) disable iff (rst)
    advance && is_query |=> pending == '0)
    else $error("pending marks not cleared by query");

  a_event_zero_flags: assert property (@(posedge clk) disable iff (rst)
    advance && !is_query |=> out_ch.click_flags == '0 && out_ch.press_x == '0
      && out_ch.release_x == '0)
    else $error("event word carries click data");

  a_raw_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(raw_x) <= RAW_WIDTH - 1 && 32'(raw_y) <= RAW_HEIGHT - 1)
    else $error("raw position out of range");

  a_no_focus_hold: assert property (@(posedge clk) disable iff (rst)
    advance && !is_query && !flags.has_focus |=>
      $stable(raw_x) && $stable(raw_y) && $stable(pending) && $stable(screen_x))
    else $error("state changed without focus");
`endif

endmodule

// File: design/mouse_pointer_tracker_unit.sv
// Mouse pointer tracker. Each input word is a mouse event (absolute mickey
// counts, buttons, event mask) or a click query, and yields exactly one
// result word, in order. An accepted word is held in the input register;
// from there the wrapped deltas are added and the raw position is
// clamped to RAW_WIDTH x RAW_HEIGHT and scaled to the display with a single
// multiply per axis by a reciprocal factor (display size times
// ceil(2^S/RAW)) that the APB block computes when a size register is
// written. A new word is taken every cycle while results are taken at the
// output; the result register lets the next word in while the previous
// result waits. Registers at byte addresses 0x0 has_focus, 0x4
// display_present, 0x8 display_width, 0xC display_height; write them only
// while the tracker is idle. Events are ignored without focus; queries
// report hold/down/up flags with the latched left press/release positions
// and clear the pending marks. No clearing pass after reset.
module mouse_pointer_tracker_unit import mpt_pkg::*; #(
  parameter int RAW_WIDTH  = DEF_RAW_WIDTH,
  parameter int RAW_HEIGHT = DEF_RAW_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  mpt_in_if.sink            in_ch,
  mpt_out_if.source         out_ch
);

  localparam int RWX = $clog2(RAW_WIDTH);
  localparam int RWY = $clog2(RAW_HEIGHT);
  localparam int KWX = RWX + 14 + COORD_W;   // (2*RWX+12) - RWX + 2 + COORD_W
  localparam int KWY = RWY + 14 + COORD_W;

  cfg_flags_t     flags;
  logic [KWX-1:0] kx;
  logic [KWY-1:0] ky;

  // register file and scale factors
  mpt_cfg #(
    .RAW_WIDTH  (RAW_WIDTH),
    .RAW_HEIGHT (RAW_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .flags   (flags),
    .kx      (kx),
    .ky      (ky)
  );

  // tracking state and word pipeline
  mpt_core #(
    .RAW_WIDTH  (RAW_WIDTH),
    .RAW_HEIGHT (RAW_HEIGHT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .flags  (flags),
    .kx     (kx),
    .ky     (ky),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
